### rtl/core/ilrw_pkg.sv
// Package for the LED controller register write pointer.
// Holds the request and response payload types, event codes and range constants.
// No dependencies; every other file of the block uses it.
package ilrw_pkg;

   typedef enum logic [1:0] {
      OP_MATCH  = 2'd0,
      OP_BYTE   = 2'd1,
      OP_STOP   = 2'd2,
      OP_IGNORE = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      AI_OFF          = 3'b000,
      AI_RSVD_1       = 3'b001,
      AI_RSVD_2       = 3'b010,
      AI_RSVD_3       = 3'b011,
      AI_ALL          = 3'b100,
      AI_BRIGHT       = 3'b101,
      AI_GROUP        = 3'b110,
      AI_BRIGHT_GROUP = 3'b111
   } ai_code_type;

   localparam logic [3:0] RANGE_ALL_START    = 4'h0;
   localparam logic [3:0] RANGE_BRIGHT_START = 4'h2;
   localparam logic [3:0] RANGE_BRIGHT_END   = 4'h5;
   localparam logic [3:0] RANGE_GROUP_START  = 4'h6;
   localparam logic [3:0] RANGE_GROUP_END    = 4'h7;

   typedef struct packed {
      op_type     op;
      logic [7:0] data_byte;
   } req_payload_type;

   typedef struct packed {
      logic       write_valid;
      logic [3:0] write_index;
      logic [7:0] write_data;
      logic       write_dropped;
      logic       transfer_done;
      logic [7:0] transfer_length;
   } rsp_payload_type;

endpackage

### rtl/core/ilrw_req_if.sv
// Request channel interface: valid/ready handshake carrying one bus event.
// Depends on ilrw_pkg for the payload type.
interface ilrw_req_if;
   logic                     valid;
   logic                     ready;
   ilrw_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### rtl/core/ilrw_rsp_if.sv
// Response channel interface: valid/ready handshake carrying one write report.
// Depends on ilrw_pkg for the payload type.
interface ilrw_rsp_if;
   logic                     valid;
   logic                     ready;
   ilrw_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### rtl/core/i2c_led_register_write_pointer.sv
// Register pointer front end of a bus-attached LED controller.
// Each accepted request's response is registered in the output register.
// Throughput: one request per cycle; a request is taken whenever the output register
// is empty or is being drained in the same cycle.
// Reset (synchronous, active high) clears the byte count, address flag, auto-increment
// flag, pointer, range bounds and the response valid flag.
module i2c_led_register_write_pointer #(
   parameter int NUM_REGS = 13
) (
   input  logic       clock,
   input  logic       reset,
   ilrw_req_if.sink   req_ch,
   ilrw_rsp_if.source rsp_ch
);

   logic                      req_accept;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   ilrw_pkg::rsp_payload_type rsp_data_ff;
   ilrw_pkg::rsp_payload_type rsp_data_in;

   logic [7:0] count_ff,      count_in;
   logic       addressed_ff,  addressed_in;
   logic       auto_inc_ff,   auto_inc_in;
   logic [3:0] pointer_ff,    pointer_in;
   logic [3:0] range_start_ff, range_start_in;
   logic [3:0] range_end_ff,  range_end_in;

   logic [4:0] pointer_inc;
   logic [3:0] pointer_adv;
   logic       pointer_in_bounds;

   assign req_ch.ready   = !rsp_valid_ff || rsp_ch.ready;
   assign req_accept     = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_data_ff;

   assign pointer_inc       = {1'b0, pointer_ff} + 5'd1;
   assign pointer_adv       = (pointer_inc > {1'b0, range_end_ff}) ? range_start_ff
                                                                   : pointer_inc[3:0];
   assign pointer_in_bounds = ({1'b0, pointer_ff} < 5'(NUM_REGS));

   always_comb begin
      count_in       = count_ff;
      addressed_in   = addressed_ff;
      auto_inc_in    = auto_inc_ff;
      pointer_in     = pointer_ff;
      range_start_in = range_start_ff;
      range_end_in   = range_end_ff;
      rsp_data_in    = '0;

      unique case (req_ch.payload.op)
         ilrw_pkg::OP_MATCH: begin
            count_in     = 8'd0;
            addressed_in = 1'b1;
         end
         ilrw_pkg::OP_BYTE: begin
            if (addressed_ff) begin
               if (count_ff == 8'd0) begin
                  // Control byte: load the pointer and pick the auto-increment range.
                  pointer_in  = req_ch.payload.data_byte[3:0];
                  auto_inc_in = 1'b1;
                  case (ilrw_pkg::ai_code_type'(req_ch.payload.data_byte[7:5]))
                     ilrw_pkg::AI_ALL: begin
                        range_start_in = ilrw_pkg::RANGE_ALL_START;
                        range_end_in   = 4'(NUM_REGS - 1);
                     end
                     ilrw_pkg::AI_BRIGHT: begin
                        range_start_in = ilrw_pkg::RANGE_BRIGHT_START;
                        range_end_in   = ilrw_pkg::RANGE_BRIGHT_END;
                     end
                     ilrw_pkg::AI_GROUP: begin
                        range_start_in = ilrw_pkg::RANGE_GROUP_START;
                        range_end_in   = ilrw_pkg::RANGE_GROUP_END;
                     end
                     ilrw_pkg::AI_BRIGHT_GROUP: begin
                        range_start_in = ilrw_pkg::RANGE_BRIGHT_START;
                        range_end_in   = ilrw_pkg::RANGE_GROUP_END;
                     end
                     default: begin
                        auto_inc_in = 1'b0;
                     end
                  endcase
               end else begin
                  if (pointer_in_bounds) begin
                     rsp_data_in.write_valid = 1'b1;
                     rsp_data_in.write_index = pointer_ff;
                     rsp_data_in.write_data  = req_ch.payload.data_byte;
                  end else begin
                     rsp_data_in.write_dropped = 1'b1;
                  end
                  if (auto_inc_ff) begin
                     pointer_in = pointer_adv;
                  end
               end
            end
            // The count runs even when not addressed, and wraps at 256.
            count_in = count_ff + 8'd1;
         end
         ilrw_pkg::OP_STOP: begin
            if (addressed_ff) begin
               rsp_data_in.transfer_done   = 1'b1;
               rsp_data_in.transfer_length = count_ff;
               count_in                    = 8'd0;
            end
            addressed_in = 1'b0;
         end
         ilrw_pkg::OP_IGNORE: begin
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = req_accept || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff   <= 1'b0;
         count_ff       <= 8'd0;
         addressed_ff   <= 1'b0;
         auto_inc_ff    <= 1'b0;
         pointer_ff     <= 4'd0;
         range_start_ff <= 4'd0;
         range_end_ff   <= 4'd0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            count_ff       <= count_in;
            addressed_ff   <= addressed_in;
            auto_inc_ff    <= auto_inc_in;
            pointer_ff     <= pointer_in;
            range_start_ff <= range_start_in;
            range_end_ff   <= range_end_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // A stalled response must block new requests.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ch.ready) |-> !req_ch.ready)
      else $error("request accepted while response is stalled");

   // A response never reports both a write and a dropped write.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.write_valid && rsp_data_ff.write_dropped))
      else $error("write and drop flagged together");

   // Reported writes always target an existing register.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.write_valid) |->
         ({1'b0, rsp_data_ff.write_index} < 5'(NUM_REGS)))
      else $error("write to a register beyond the register count");

   // An accepted stop always leaves the block unaddressed.
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_ch.payload.op == ilrw_pkg::OP_STOP) |=> !addressed_ff)
      else $error("still addressed after a stop");

endmodule

### sim/tb.sv
`timescale 1ns / 100ps
// Testbench for the LED controller register write pointer.
// Drives bus events and checks each write report against an in-bench predictor.
// Depends on ilrw_pkg, the two channel interfaces and the top level.
module tb;

   localparam int NUM_REGS          = 13;
   localparam int LONG_STALL_CYCLES = 200;
   localparam int WATCHDOG_LIMIT    = 2000;

   logic clock;
   logic reset;

   ilrw_req_if req_ch ();
   ilrw_rsp_if rsp_ch ();

   i2c_led_register_write_pointer #(
      .NUM_REGS (NUM_REGS)
   ) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Predicted slave state.
   logic [7:0] byte_count;
   logic       is_addressed;
   logic       advance_on;
   logic [3:0] pointer;
   logic [3:0] wrap_start;
   logic [3:0] wrap_end;

   ilrw_pkg::rsp_payload_type expected_reports[$];

   int  error_count;
   int  events_sent;
   int  requests_taken;
   int  reports_checked;
   int  writes_predicted;
   int  drops_predicted;
   int  transfers_reported;
   int  quiet_cycles;
   bit  req_idle_on;
   bit  rsp_idle_on;
   bit  long_stall_request;
   bit  long_stall_done;
   int  rsp_stall_left;

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // Works out the report for one accepted request and updates the predicted state.
   function automatic ilrw_pkg::rsp_payload_type predict_write_report(
      input ilrw_pkg::req_payload_type req);
      ilrw_pkg::rsp_payload_type rsp;
      logic [4:0]                next_ptr;
      rsp = '0;
      case (req.op)
         ilrw_pkg::OP_MATCH: begin
            byte_count   = 8'd0;
            is_addressed = 1'b1;
         end
         ilrw_pkg::OP_BYTE: begin
            if (is_addressed) begin
               if (byte_count == 8'd0) begin
                  pointer    = req.data_byte[3:0];
                  advance_on = 1'b1;
                  case (ilrw_pkg::ai_code_type'(req.data_byte[7:5]))
                     ilrw_pkg::AI_ALL: begin
                        wrap_start = ilrw_pkg::RANGE_ALL_START;
                        wrap_end   = 4'(NUM_REGS - 1);
                     end
                     ilrw_pkg::AI_BRIGHT: begin
                        wrap_start = ilrw_pkg::RANGE_BRIGHT_START;
                        wrap_end   = ilrw_pkg::RANGE_BRIGHT_END;
                     end
                     ilrw_pkg::AI_GROUP: begin
                        wrap_start = ilrw_pkg::RANGE_GROUP_START;
                        wrap_end   = ilrw_pkg::RANGE_GROUP_END;
                     end
                     ilrw_pkg::AI_BRIGHT_GROUP: begin
                        wrap_start = ilrw_pkg::RANGE_BRIGHT_START;
                        wrap_end   = ilrw_pkg::RANGE_GROUP_END;
                     end
                     default: advance_on = 1'b0;
                  endcase
               end else begin
                  if (int'(pointer) < NUM_REGS) begin
                     rsp.write_valid = 1'b1;
                     rsp.write_index = pointer;
                     rsp.write_data  = req.data_byte;
                     writes_predicted++;
                  end else begin
                     rsp.write_dropped = 1'b1;
                     drops_predicted++;
                  end
                  if (advance_on) begin
                     next_ptr = {1'b0, pointer} + 5'd1;
                     if (next_ptr > {1'b0, wrap_end})
                        next_ptr = {1'b0, wrap_start};
                     pointer = next_ptr[3:0];
                  end
               end
            end
            byte_count = byte_count + 8'd1;
         end
         ilrw_pkg::OP_STOP: begin
            if (is_addressed) begin
               rsp.transfer_done   = 1'b1;
               rsp.transfer_length = byte_count;
               byte_count          = 8'd0;
               transfers_reported++;
            end
            is_addressed = 1'b0;
         end
         default: ;
      endcase
      return rsp;
   endfunction

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   // Checks responses, predicts accepted requests and watches for a hang.
   always @(posedge clock) begin
      ilrw_pkg::rsp_payload_type want;
      ilrw_pkg::rsp_payload_type got;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = rsp_ch.payload;
            if (expected_reports.size() == 0) begin
               $error("Response with no request outstanding: %h", got);
               error_count++;
            end else begin
               want = expected_reports.pop_front();
               check_field("write_valid", want.write_valid, got.write_valid);
               check_field("write_index", want.write_index, got.write_index);
               check_field("write_data", want.write_data, got.write_data);
               check_field("write_dropped", want.write_dropped, got.write_dropped);
               check_field("transfer_done", want.transfer_done, got.transfer_done);
               check_field("transfer_length", want.transfer_length,
                           got.transfer_length);
            end
            reports_checked++;
         end
         if (req_ch.valid && req_ch.ready) begin
            expected_reports.push_back(predict_write_report(req_ch.payload));
            requests_taken++;
         end
         if ((rsp_ch.valid && rsp_ch.ready) || (req_ch.valid && req_ch.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // Response side: random stall bursts plus one long hold-off on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_stall_left = 0;
      end else if (long_stall_request && !long_stall_done) begin
         long_stall_done = 1'b1;
         rsp_stall_left  = LONG_STALL_CYCLES - 1;
         rsp_ch.ready <= 1'b0;
      end else if (rsp_stall_left > 0) begin
         rsp_stall_left--;
         rsp_ch.ready <= 1'b0;
      end else if (rsp_idle_on && $urandom_range(0, 9) == 0) begin
         rsp_stall_left = $urandom_range(1, 12) - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // Offers one bus event and returns at the edge where it is accepted.
   task automatic send_event(input ilrw_pkg::op_type op, input logic [7:0] data);
      if (req_idle_on && $urandom_range(0, 7) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_ch.valid             <= 1'b1;
      req_ch.payload.op        <= op;
      req_ch.payload.data_byte <= data;
      do @(posedge clock); while (!req_ch.ready);
      if (op != ilrw_pkg::OP_IGNORE)
         events_sent++;
   endtask

   function automatic logic [7:0] random_control_byte();
      logic [2:0] code;
      logic [3:0] ptr;
      // Mostly valid range codes and in-range pointers, the rest anything.
      code = ($urandom_range(0, 9) < 7) ? 3'($urandom_range(4, 7)) : 3'($urandom);
      ptr  = ($urandom_range(0, 9) < 8) ? 4'($urandom_range(0, NUM_REGS - 1))
                                        : 4'($urandom);
      return {code, 1'b0, ptr} | {3'b000, 1'($urandom), 4'b0000};
   endfunction

   // Well-formed transfers with random content, mixed with noise and broken ones.
   task automatic run_transfers(input int event_target, input bit vary_idle);
      int start_count;
      int data_len;
      int pick;
      start_count = events_sent;
      while (events_sent - start_count < event_target) begin
         if (vary_idle && $urandom_range(0, 7) == 0) begin
            req_idle_on = ($urandom_range(0, 3) != 0);
            rsp_idle_on = ($urandom_range(0, 3) != 0);
         end
         pick = $urandom_range(0, 19);
         if (pick < 2) begin
            repeat ($urandom_range(1, 4))
               send_event(ilrw_pkg::op_type'($urandom_range(0, 3)), 8'($urandom));
         end else begin
            send_event(ilrw_pkg::OP_MATCH, 8'($urandom));
            send_event(ilrw_pkg::OP_BYTE, random_control_byte());
            data_len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40)
                                                  : $urandom_range(0, 16);
            for (int i = 0; i < data_len; i++) begin
               if ($urandom_range(0, 49) == 0)
                  send_event(ilrw_pkg::OP_IGNORE, 8'($urandom));
               send_event(ilrw_pkg::OP_BYTE, 8'($urandom));
            end
            // Now and then the stop is left out, so the next match repeats.
            if (pick != 2)
               send_event(ilrw_pkg::OP_STOP, 8'($urandom));
         end
      end
   endtask

   task automatic test_directed_events();
      send_event(ilrw_pkg::OP_STOP, 8'h00);
      send_event(ilrw_pkg::OP_BYTE, 8'hFF);
      send_event(ilrw_pkg::OP_IGNORE, 8'hFF);
      send_event(ilrw_pkg::OP_MATCH, 8'h00);
      send_event(ilrw_pkg::OP_BYTE, 8'h80);
      send_event(ilrw_pkg::OP_BYTE, 8'h00);
      send_event(ilrw_pkg::OP_BYTE, 8'hFF);
      // Repeated match mid-transfer; the pointer then wraps from the top register.
      send_event(ilrw_pkg::OP_MATCH, 8'hFF);
      send_event(ilrw_pkg::OP_BYTE, 8'h8C);
      send_event(ilrw_pkg::OP_BYTE, 8'h5A);
      send_event(ilrw_pkg::OP_BYTE, 8'hA5);
      send_event(ilrw_pkg::OP_STOP, 8'hFF);
      // Auto-increment off with the pointer beyond the register count.
      send_event(ilrw_pkg::OP_MATCH, 8'h00);
      send_event(ilrw_pkg::OP_BYTE, 8'h0D);
      send_event(ilrw_pkg::OP_BYTE, 8'h11);
      send_event(ilrw_pkg::OP_BYTE, 8'h22);
      // Pointer 15 in the brightness range wraps to the range start.
      send_event(ilrw_pkg::OP_MATCH, 8'h00);
      send_event(ilrw_pkg::OP_BYTE, 8'hAF);
      send_event(ilrw_pkg::OP_BYTE, 8'h33);
      send_event(ilrw_pkg::OP_BYTE, 8'h44);
      send_event(ilrw_pkg::OP_MATCH, 8'h00);
      send_event(ilrw_pkg::OP_BYTE, 8'h27);
      send_event(ilrw_pkg::OP_BYTE, 8'h55);
      send_event(ilrw_pkg::OP_MATCH, 8'h00);
      send_event(ilrw_pkg::OP_BYTE, 8'h4E);
      send_event(ilrw_pkg::OP_BYTE, 8'h66);
      send_event(ilrw_pkg::OP_MATCH, 8'h00);
      send_event(ilrw_pkg::OP_BYTE, 8'h61);
      send_event(ilrw_pkg::OP_BYTE, 8'h77);
      // Pointer below the brightness-plus-group range counts up into it.
      send_event(ilrw_pkg::OP_MATCH, 8'h00);
      send_event(ilrw_pkg::OP_BYTE, 8'hE0);
      repeat (3) send_event(ilrw_pkg::OP_BYTE, 8'($urandom));
      send_event(ilrw_pkg::OP_MATCH, 8'h00);
      send_event(ilrw_pkg::OP_BYTE, 8'hC7);
      repeat (3) send_event(ilrw_pkg::OP_BYTE, 8'($urandom));
      send_event(ilrw_pkg::OP_STOP, 8'h00);
   endtask

   // The byte count wraps, so a byte after 255 data bytes is a new control byte.
   task automatic test_count_wrap();
      send_event(ilrw_pkg::OP_MATCH, 8'h00);
      send_event(ilrw_pkg::OP_BYTE, random_control_byte());
      repeat (255) send_event(ilrw_pkg::OP_BYTE, 8'($urandom));
      send_event(ilrw_pkg::OP_BYTE, 8'hA3);
      repeat (3) send_event(ilrw_pkg::OP_BYTE, 8'($urandom));
      send_event(ilrw_pkg::OP_STOP, 8'h00);
   endtask

   task automatic test_random_traffic();
      run_transfers(1000, 1'b1);
   endtask

   // The receiver holds off while requests keep coming, so the input stalls.
   task automatic test_output_backpressure();
      req_idle_on = 1'b0;
      long_stall_request = 1'b1;
      run_transfers(40, 1'b0);
      long_stall_request = 1'b0;
      req_idle_on = 1'b1;
   endtask

   task automatic test_steady_stream();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      run_transfers(150, 1'b0);
   endtask

   initial begin
      reset <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.payload <= '0;
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      long_stall_request = 1'b0;
      long_stall_done    = 1'b0;
      error_count = 0;
      events_sent = 0;
      requests_taken = 0;
      reports_checked = 0;
      writes_predicted = 0;
      drops_predicted = 0;
      transfers_reported = 0;
      quiet_cycles = 0;
      byte_count   = '0;
      is_addressed = 1'b0;
      advance_on   = 1'b0;
      pointer      = '0;
      wrap_start   = '0;
      wrap_end     = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_events();
      test_count_wrap();
      test_random_traffic();
      test_output_backpressure();
      test_steady_stream();

      req_ch.valid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      $display("Checked %0d reports for %0d requests: %0d register writes, %0d dropped",
               reports_checked, requests_taken, writes_predicted, drops_predicted);
      $display("bytes and %0d completed transfers, including a byte count wrap.",
               transfers_reported);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
